// ===== design/cppt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cppt_pkg
// Types and constants shared by the connection port pool table.
// ---------------------------------------------------------------------------
package cppt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned CmdQDepth = 2;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_UPDATE = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_STATUS = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_POOL      = 2'd1,
    RC_NOT_FOUND = 2'd2,
    RC_NO_SLOT   = 2'd3
  } rc_e;

  typedef enum logic [1:0] {
    REG_MAX_CONN = 2'd0,
    REG_RELOAD   = 2'd1,
    REG_PAUSE    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] client_addr;
    logic [4:0]  want_ports;
    logic [15:0] first_port;
    logic [3:0]  slot_index;
    logic [1:0]  new_status;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [3:0]  slot_out;
    logic [4:0]  granted;
    logic [15:0] first_port_out;
    logic [1:0]  conn_status;
    logic [4:0]  free_ports_out;
    logic        expired;
    logic [31:0] expired_addr;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// ===== design/cppt_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cppt_front
// Command queue: accepts items and holds them until the engine takes one.
// ---------------------------------------------------------------------------
module cppt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cppt_pkg::in_item_t  item_i,
  output logic                full_o,
  output logic                valid_o,
  output cppt_pkg::in_item_t  item_o,
  input  logic                take_i
);
  import cppt_pkg::*;

  localparam int unsigned PtrW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;

  in_item_t              mem_q [CmdQDepth];
  logic [PtrW-1:0]       wp_q, rp_q;
  logic [PtrW:0]         cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(CmdQDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PtrW'(CmdQDepth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == PtrW'(CmdQDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

// ===== design/cppt_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cppt_engine
// Slot table and sequencer: scans a slot a cycle unless stalled, emits items.
// ---------------------------------------------------------------------------
module cppt_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cppt_pkg::cfg_wr_t   cfg_i,
  input  logic                cmd_valid_i,
  input  cppt_pkg::in_item_t  cmd_i,
  output logic                cmd_take_o,
  output logic                res_valid_o,
  output cppt_pkg::out_item_t res_o,
  input  logic                res_pop_i,
  output logic                busy_o
);
  import cppt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_e;

  localparam int unsigned CntW = SlotW + 1;

  logic [TableEntries-1:0] used_q;
  logic [31:0]             addr_q  [TableEntries];
  logic [15:0]             port_q  [TableEntries];
  logic [4:0]              count_q [TableEntries];
  logic [1:0]              stat_q  [TableEntries];
  logic [15:0]             timer_q [TableEntries];
  logic [4:0]              pool_q, maxc_q;
  logic [15:0]             reload_q;
  logic [1:0]              pause_q;

  state_e                  state_q;
  in_item_t                cur_q;
  logic [CntW-1:0]         idx_q;
  out_item_t               res_q;
  logic                    resv_q;

  logic [CntW-1:0]         n_eff;
  logic [SlotW-1:0]        si;
  logic                    in_rng;
  logic [4:0]              grant_add, pool_ret, grant_upd;
  logic [15:0]             tdec;
  logic                    slot_hit;
  logic                    resv_set;

  always_comb begin
    if (32'(maxc_q) > TableEntries) n_eff = CntW'(TableEntries);
    else n_eff = CntW'(maxc_q);
  end

  assign si        = idx_q[SlotW-1:0];
  assign in_rng    = idx_q < n_eff;
  assign grant_add = (cur_q.want_ports < pool_q) ? cur_q.want_ports : pool_q;
  assign pool_ret  = pool_q + count_q[si];
  assign grant_upd = (cur_q.want_ports < pool_ret) ? cur_q.want_ports : pool_ret;
  assign tdec      = (timer_q[si] != '0) ? timer_q[si] - 16'd1 : timer_q[si];
  assign slot_hit  = used_q[si] && addr_q[si] == cur_q.client_addr;

  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i && !cfg_i.wr;
  assign res_valid_o = resv_q;
  assign res_o       = res_q;
  assign busy_o      = (state_q != S_IDLE) || resv_q;

  // load the output register on an expiry item or when leaving S_OUT
  always_comb begin
    resv_set = 1'b0;
    if (!resv_q || res_pop_i) begin
      if (state_q == S_OUT) resv_set = 1'b1;
      else if (state_q == S_SCAN && cur_q.cmd == CMD_TICK && in_rng && used_q[si] &&
               stat_q[si] != pause_q && tdec == '0) resv_set = 1'b1;
    end
  end

  function automatic out_item_t mk(rc_e rc, logic [3:0] s, logic [4:0] g,
                                   logic [15:0] p, logic [1:0] st, logic [4:0] fr,
                                   logic ex, logic [31:0] ea, logic l);
    out_item_t o;
    o.result_code = rc; o.slot_out = s; o.granted = g; o.first_port_out = p;
    o.conn_status = st; o.free_ports_out = fr; o.expired = ex;
    o.expired_addr = ea; o.last = l;
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      pool_q   <= 5'd16;
      maxc_q   <= 5'd16;
      reload_q <= 16'd30;
      pause_q  <= 2'd1;
      resv_q   <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        addr_q[i] <= '0; port_q[i] <= '0; count_q[i] <= '0;
        stat_q[i] <= '0; timer_q[i] <= '0;
      end
    end else begin
      if (resv_set) resv_q <= 1'b1;
      else if (res_pop_i) resv_q <= 1'b0;
      if (cfg_i.wr) begin
        case (cfg_i.idx)
          REG_MAX_CONN: begin
            maxc_q <= cfg_i.data[4:0];
            used_q <= '0;
            pool_q <= (32'(cfg_i.data[4:0]) > TableEntries) ? 5'(TableEntries)
                                                            : cfg_i.data[4:0];
            for (int i = 0; i < TableEntries; i++) begin
              addr_q[i] <= '0; port_q[i] <= '0; count_q[i] <= '0;
              stat_q[i] <= '0; timer_q[i] <= '0;
            end
          end
          REG_RELOAD: reload_q <= cfg_i.data;
          REG_PAUSE:  pause_q  <= cfg_i.data[1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            cur_q   <= cmd_i;
            idx_q   <= (cmd_i.cmd == CMD_UPDATE) ? CntW'(cmd_i.slot_index) : '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!resv_q || res_pop_i) begin
            // steps only while res_q is free; results go out through res_q
            case (cur_q.cmd)
              CMD_ADD: begin
                state_q <= S_OUT;
                if (pool_q == '0)
                  res_q <= mk(RC_POOL, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                else if (!in_rng)
                  res_q <= mk(RC_NO_SLOT, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                else if (!used_q[si]) begin
                  used_q[si] <= 1'b1; addr_q[si] <= cur_q.client_addr;
                  port_q[si] <= cur_q.first_port; count_q[si] <= grant_add;
                  stat_q[si] <= '0; timer_q[si] <= reload_q;
                  pool_q <= pool_q - grant_add;
                  res_q <= mk(RC_OK, 4'(si), grant_add, cur_q.first_port, '0,
                              pool_q - grant_add, 1'b0, '0, 1'b1);
                end else begin
                  idx_q <= idx_q + 1'b1; state_q <= S_SCAN;
                end
              end
              CMD_UPDATE: begin
                state_q <= S_OUT;
                if (!in_rng || !used_q[si])
                  res_q <= mk(RC_NOT_FOUND, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                else begin
                  timer_q[si] <= reload_q;
                  port_q[si]  <= cur_q.first_port;
                  if (count_q[si] != cur_q.want_ports) begin
                    count_q[si] <= grant_upd;
                    pool_q <= pool_ret - grant_upd;
                    res_q <= mk(RC_OK, 4'(si), grant_upd, cur_q.first_port,
                                stat_q[si], pool_ret - grant_upd, 1'b0, '0, 1'b1);
                  end else
                    res_q <= mk(RC_OK, 4'(si), count_q[si], cur_q.first_port,
                                stat_q[si], pool_q, 1'b0, '0, 1'b1);
                end
              end
              CMD_REMOVE, CMD_LOOKUP, CMD_STATUS: begin
                state_q <= S_OUT;
                if (!in_rng)
                  res_q <= mk(RC_NOT_FOUND, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                else if (slot_hit) begin
                  if (cur_q.cmd == CMD_REMOVE) begin
                    used_q[si] <= 1'b0; addr_q[si] <= '0; port_q[si] <= '0;
                    count_q[si] <= '0; stat_q[si] <= '0; timer_q[si] <= '0;
                    pool_q <= pool_ret;
                    res_q <= mk(RC_OK, 4'(si), count_q[si], port_q[si], stat_q[si],
                                pool_ret, 1'b0, '0, 1'b1);
                  end else if (cur_q.cmd == CMD_LOOKUP)
                    res_q <= mk(RC_OK, 4'(si), count_q[si], port_q[si], stat_q[si],
                                pool_q, 1'b0, '0, 1'b1);
                  else begin
                    stat_q[si] <= cur_q.new_status; timer_q[si] <= reload_q;
                    res_q <= mk(RC_OK, 4'(si), count_q[si], port_q[si],
                                cur_q.new_status, pool_q, 1'b0, '0, 1'b1);
                  end
                end else begin
                  idx_q <= idx_q + 1'b1; state_q <= S_SCAN;
                end
              end
              CMD_TICK: begin
                if (!in_rng) begin
                  res_q <= mk(RC_OK, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                  state_q <= S_OUT;
                end else begin
                  idx_q <= idx_q + 1'b1;
                  if (used_q[si] && stat_q[si] != pause_q) begin
                    if (tdec == '0) begin
                      used_q[si] <= 1'b0; addr_q[si] <= '0; port_q[si] <= '0;
                      count_q[si] <= '0; stat_q[si] <= '0; timer_q[si] <= '0;
                      pool_q <= pool_ret;
                      res_q <= mk(RC_OK, 4'(si), count_q[si], port_q[si],
                                  stat_q[si], pool_ret, 1'b1, addr_q[si], 1'b0);
                    end else timer_q[si] <= tdec;
                  end
                end
              end
              default: begin
                res_q <= mk(RC_OK, '0, '0, '0, '0, pool_q, 1'b0, '0, 1'b1);
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!resv_q || res_pop_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/connection_port_pool_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// connection_port_pool_table
// Client connection table with a shared port pool and idle timeout.
// ---------------------------------------------------------------------------
// Use: commands enter through push/full and are held in a two-deep
// command queue. The engine takes one command at a time and scans the slot
// table one slot per cycle while the output register is free, taking the
// command, stepping through the slots up to one past the last and then
// loading the output register; tick visits every slot below max_connections
// and emits one item per expired slot plus a closing item with last set.
// Results leave through a one-item output register (empty/pop); while it
// is not popped the scan holds, and the command queue keeps accepting
// until it fills. Configuration writes go through cfg_valid_i/cfg_ready_o
// and are taken only while the engine is idle and the command queue is
// empty; writing max_connections clears the table and reloads the pool.
// Reset empties the table, sets the pool to 16, the timeout to 30 ticks
// and the pause status to 1.
// ---------------------------------------------------------------------------
module connection_port_pool_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  cppt_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output cppt_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import cppt_pkg::*;

  logic      q_valid, q_take, res_valid, busy;
  in_item_t  q_item;
  cfg_wr_t   cfg;

  cppt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item_i), .full_o(full),
    .valid_o(q_valid), .item_o(q_item), .take_i(q_take)
  );

  assign cfg_ready_o = !busy && !q_valid;
  assign cfg.wr   = cfg_valid_i && cfg_ready_o;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_data_i;

  cppt_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_valid_i(q_valid), .cmd_i(q_item),
    .cmd_take_o(q_take), .res_valid_o(res_valid), .res_o(out_item_o),
    .res_pop_i(pop), .busy_o(busy)
  );

  assign empty = !res_valid;

  a_no_take_on_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.wr |-> !q_take) else $error("command taken during config write");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while stalled");
  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.free_ports_out <= 5'd16) else $error("pool overflow");

endmodule
